/* hw/rtl/rfsb_pkg.sv */
// Shared types, constants and pixel functions for the rectangle fill and shadow blitter.
package rfsb_pkg;

  // Pixel store geometry.
  localparam int unsigned STORE_WORDS = 65536;
  localparam int unsigned ADDR_W      = $clog2(STORE_WORDS);

  // Field and register widths.
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SIZE_W  = 12;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned CLIP_W  = COORD_W + 2;
  localparam int unsigned BASE_W  = 2 * CFG_W;
  localparam int unsigned SUM_W   = BASE_W + 1;
  localparam int unsigned QUO_W   = 8;

  // Register reset values.
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd256;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd256;
  localparam logic [CFG_W-1:0] ROW_PITCH_RST    = 13'd256;

  // Shading and gradient constants.
  localparam logic [15:0]      SHADE_MUL   = 16'd185;  // 255 - 70
  localparam logic [CFG_W-1:0] GRAD_STEP   = 13'd140;
  localparam logic [7:0]       GRAD_BASE   = 8'd60;
  localparam logic [7:0]       GRAD_RED    = 8'h0A;
  localparam logic [7:0]       GRAD_GREEN  = 8'h28;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_ROW_PITCH    = 2'd2
  } cfg_idx_t;

  // Command operations.
  typedef enum logic [1:0] {
    OP_FILL     = 2'd0,
    OP_SHADOW   = 2'd1,
    OP_GRADIENT = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_ROW,
    ST_GDIV,
    ST_PIX,
    ST_SHW,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_DONE
  } state_t;

  // One access to the pixel store.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } mem_req_t;

  // channel * 185 / 255, truncated; the divide by 255 uses the
  // (v + (v >> 8) + 1) >> 8 identity, exact for v below 65535.
  function automatic logic [7:0] darken_ch(input logic [7:0] c);
    logic [15:0] v;
    logic [16:0] s;
    v = {8'h00, c} * SHADE_MUL;
    s = {1'b0, v} + {9'h000, v[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  // Darken three channels and clear the top byte.
  function automatic logic [PIX_W-1:0] darken_px(input logic [PIX_W-1:0] p);
    return {8'h00, darken_ch(p[23:16]), darken_ch(p[15:8]), darken_ch(p[7:0])};
  endfunction

endpackage

/* hw/rtl/rfsb_store.sv */
// Single-port pixel store with registered read data.
module rfsb_store (
  input  logic                            clk,
  input  rfsb_pkg::mem_req_t              req,
  output logic [rfsb_pkg::PIX_W-1:0]      rdata
);
  import rfsb_pkg::*;

  logic [PIX_W-1:0] mem [STORE_WORDS];

  // One write or one read per cycle.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

/* hw/rtl/rect_fill_shadow_blitter.sv */
// Top level of the rectangle fill, shadow, gradient and pixel read engine.
//
// Usage: a command item is taken on start while busy is low. Every command
// gives exactly one result, shown on out_read_pixel and out_read_hit for a
// single cycle with out_valid high; the receiver cannot stall it. busy stays
// high from the accepted item up to and including the result cycle.
// Configuration writes (cfg_index, cfg_data) are taken on every cycle that
// cfg_valid is high; cfg_ready is tied high.
// After reset a clearing pass writes zero to all 65536 store words, one per
// cycle, and busy stays high until that pass ends.
// The single-port store and the one address adder set the pace. Fill writes
// one pixel per visit to the pixel state; shadow reads each pixel and then
// writes it back darkened; gradient runs the divide at the start of each
// row over the whole frame; a read addresses the store, then takes its data.
// A command that clips to nothing, or a read outside the frame, skips to the
// result. Rows or pixels that land beyond the store end their loop early.
module rect_fill_shadow_blitter (
  input  logic                            clk,
  input  logic                            rst_n,
  // Command channel.
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_operation,
  input  logic signed [rfsb_pkg::COORD_W-1:0] in_rect_x,
  input  logic signed [rfsb_pkg::COORD_W-1:0] in_rect_y,
  input  logic [rfsb_pkg::SIZE_W-1:0]     in_rect_w,
  input  logic [rfsb_pkg::SIZE_W-1:0]     in_rect_h,
  input  logic [rfsb_pkg::PIX_W-1:0]      in_fill_color,
  // Result channel.
  output logic                            out_valid,
  output logic [rfsb_pkg::PIX_W-1:0]      out_read_pixel,
  output logic                            out_read_hit,
  // Configuration channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [rfsb_pkg::CFG_W-1:0]      cfg_data
);
  import rfsb_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0] fw_r, fh_r, pitch_r;

  // Sequencer registers.
  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  logic [CFG_W-1:0]   x0_r, x0_nxt;
  logic [CFG_W-1:0]   x1_r, x1_nxt;
  logic [CFG_W-1:0]   col_r, col_nxt;
  logic [CFG_W-1:0]   y_r, y_nxt;
  logic [CFG_W-1:0]   y1_r, y1_nxt;
  logic [BASE_W-1:0]  base_r, base_nxt;
  logic [PIX_W-1:0]   color_r, color_nxt;
  // The remainder plus one gradient step can pass the 13-bit range.
  logic [CFG_W:0]     rem_r, rem_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [PIX_W-1:0]   pix_r, pix_nxt;
  logic               hit_r, hit_nxt;

  // Store port.
  mem_req_t           mem_req;
  logic [PIX_W-1:0]   mem_rdata;

  // Clipping of the incoming rectangle against the frame.
  logic signed [CLIP_W-1:0] x_s, y_s, xe_s, ye_s, fw_s, fh_s;
  logic signed [CLIP_W-1:0] cx0, cx1, cy0, cy1;
  logic                     rect_live, read_in;
  logic                     accept;

  // Shared address adder and compares.
  logic [SUM_W-1:0]   addr_sum;
  logic               addr_out;
  logic               base_out;
  logic [CFG_W-1:0]   div_val;

  assign accept = start && (state_r == ST_IDLE);

  assign x_s  = CLIP_W'(in_rect_x);
  assign y_s  = CLIP_W'(in_rect_y);
  assign xe_s = x_s + $signed({{(CLIP_W-SIZE_W){1'b0}}, in_rect_w});
  assign ye_s = y_s + $signed({{(CLIP_W-SIZE_W){1'b0}}, in_rect_h});
  assign fw_s = $signed({{(CLIP_W-CFG_W){1'b0}}, fw_r});
  assign fh_s = $signed({{(CLIP_W-CFG_W){1'b0}}, fh_r});
  assign cx0  = in_rect_x[COORD_W-1] ? '0 : x_s;
  assign cy0  = in_rect_y[COORD_W-1] ? '0 : y_s;
  assign cx1  = (xe_s > fw_s) ? fw_s : xe_s;
  assign cy1  = (ye_s > fh_s) ? fh_s : ye_s;
  assign rect_live = (cx0 < cx1) && (cy0 < cy1);
  assign read_in   = !in_rect_x[COORD_W-1] && !in_rect_y[COORD_W-1] &&
                     (x_s < fw_s) && (y_s < fh_s);

  assign addr_sum = {1'b0, base_r} + {{(SUM_W-CFG_W){1'b0}}, col_r};
  assign addr_out = addr_sum >= SUM_W'(STORE_WORDS);
  assign base_out = base_r >= BASE_W'(STORE_WORDS);
  assign div_val  = (fh_r == '0) ? CFG_W'(1) : fh_r;

  // Configuration writes; indexes beyond the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r    <= FRAME_WIDTH_RST;
      fh_r    <= FRAME_HEIGHT_RST;
      pitch_r <= ROW_PITCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  fw_r    <= cfg_data;
        CFG_FRAME_HEIGHT: fh_r    <= cfg_data;
        CFG_ROW_PITCH:    pitch_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    x0_r    <= x0_nxt;
    x1_r    <= x1_nxt;
    col_r   <= col_nxt;
    y_r     <= y_nxt;
    y1_r    <= y1_nxt;
    base_r  <= base_nxt;
    color_r <= color_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    pix_r   <= pix_nxt;
    hit_r   <= hit_nxt;
  end

  // Sequencer: next state, datapath updates and store requests.
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    op_nxt    = op_r;
    x0_nxt    = x0_r;
    x1_nxt    = x1_r;
    col_nxt   = col_r;
    y_nxt     = y_r;
    y1_nxt    = y1_r;
    base_nxt  = base_r;
    color_nxt = color_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    pix_nxt   = pix_r;
    hit_nxt   = hit_r;
    mem_req   = '0;
    mem_req.addr = addr_sum[ADDR_W-1:0];

    case (state_r)
      // Zero the whole store after reset.
      ST_CLEAR: begin
        mem_req.we   = 1'b1;
        mem_req.addr = clr_r;
        clr_nxt      = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(STORE_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      // Take a command and clip it.
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = op_t'(in_operation);
          color_nxt = in_fill_color;
          pix_nxt   = '0;
          hit_nxt   = 1'b0;
          rem_nxt   = '0;
          quo_nxt   = '0;
          case (op_t'(in_operation))
            OP_FILL, OP_SHADOW: begin
              x0_nxt    = cx0[CFG_W-1:0];
              x1_nxt    = cx1[CFG_W-1:0];
              y_nxt     = cy0[CFG_W-1:0];
              y1_nxt    = cy1[CFG_W-1:0];
              state_nxt = rect_live ? ST_SETUP : ST_DONE;
            end
            OP_GRADIENT: begin
              x0_nxt    = '0;
              x1_nxt    = fw_r;
              y_nxt     = '0;
              y1_nxt    = fh_r;
              state_nxt = ((fw_r != '0) && (fh_r != '0)) ? ST_SETUP : ST_DONE;
            end
            default: begin
              col_nxt   = in_rect_x[CFG_W-1:0];
              y_nxt     = in_rect_y[CFG_W-1:0];
              hit_nxt   = read_in;
              state_nxt = read_in ? ST_SETUP : ST_DONE;
            end
          endcase
        end
      end

      // Row base address of the first row.
      ST_SETUP: begin
        base_nxt  = {{(BASE_W-CFG_W){1'b0}}, pitch_r} * {{(BASE_W-CFG_W){1'b0}}, y_r};
        state_nxt = (op_r == OP_READ) ? ST_RD_ADDR : ST_ROW;
      end

      // Start of a row; stop when out of rows or past the store.
      ST_ROW: begin
        col_nxt = x0_r;
        if ((y_r >= y1_r) || base_out) begin
          state_nxt = ST_DONE;
        end else if (op_r == OP_GRADIENT) begin
          state_nxt = ST_GDIV;
        end else begin
          state_nxt = ST_PIX;
        end
      end

      // Gradient quotient: subtract the height until the remainder is small.
      ST_GDIV: begin
        if (rem_r >= {1'b0, div_val}) begin
          rem_nxt = rem_r - {1'b0, div_val};
          quo_nxt = quo_r + QUO_W'(1);
        end else begin
          color_nxt = {8'h00, GRAD_RED, GRAD_GREEN, GRAD_BASE + quo_r};
          state_nxt = ST_PIX;
        end
      end

      // One pixel per visit; end of row advances to the next.
      ST_PIX: begin
        if ((col_r >= x1_r) || addr_out) begin
          y_nxt     = y_r + CFG_W'(1);
          base_nxt  = base_r + {{(BASE_W-CFG_W){1'b0}}, pitch_r};
          rem_nxt   = rem_r + {1'b0, GRAD_STEP};
          state_nxt = ST_ROW;
        end else if (op_r == OP_SHADOW) begin
          mem_req.re = 1'b1;
          state_nxt  = ST_SHW;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.wdata = color_r;
          col_nxt       = col_r + CFG_W'(1);
        end
      end

      // Write back the darkened pixel.
      ST_SHW: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = darken_px(mem_rdata);
        col_nxt       = col_r + CFG_W'(1);
        state_nxt     = ST_PIX;
      end

      // Pixel read: addresses past the store read as zero.
      ST_RD_ADDR: begin
        if (addr_out) begin
          state_nxt = ST_DONE;
        end else begin
          mem_req.re = 1'b1;
          state_nxt  = ST_RD_DATA;
        end
      end

      ST_RD_DATA: begin
        pix_nxt   = mem_rdata;
        state_nxt = ST_DONE;
      end

      // Result cycle.
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  rfsb_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Outputs.
  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = (state_r == ST_DONE);
  assign out_read_pixel = pix_r;
  assign out_read_hit   = hit_r;

`ifndef SYNTHESIS
  // A result appears only while a command is in progress.
  a_result_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside a command");

  // An accepted command always makes the block busy next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not start");

  // Pixel reads never write the store.
  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_ADDR || state_r == ST_RD_DATA) |-> !mem_req.we)
    else $error("store write during pixel read");

  // Drawing commands report a zero result.
  a_draw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && op_r != OP_READ) |-> (!out_read_hit && out_read_pixel == '0))
    else $error("nonzero result for drawing command");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the rectangle fill, shadow and gradient blitter.
module tb;
  import rfsb_pkg::*;

  localparam int     HALF_PERIOD    = 10;
  localparam int     RESET_CYCLES   = 12;
  localparam int     STALL_LIMIT    = 600000;
  localparam int     SETTLE_CYCLES  = 8;
  localparam longint STORE_SIZE     = STORE_WORDS;
  localparam int     CH_MAX         = 255;
  localparam int     SHADE_DROP     = 70;
  localparam int     SHADE_KEEP     = CH_MAX - SHADE_DROP;
  localparam int     GRAD_BLUE_BASE = 60;
  localparam int     GRAD_BLUE_SPAN = 140;
  localparam logic [15:0] GRAD_RG   = 16'h0A28;
  // Register index past the end of the list; the block ignores it.
  localparam logic [1:0] CFG_IDX_SPARE = 2'd3;

  // Expected outcome of one command.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             hit;
  } blit_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  op_t                       in_operation;
  logic signed [COORD_W-1:0] in_rect_x;
  logic signed [COORD_W-1:0] in_rect_y;
  logic [SIZE_W-1:0]         in_rect_w;
  logic [SIZE_W-1:0]         in_rect_h;
  logic [PIX_W-1:0]          in_fill_color;
  logic                      out_valid;
  logic [PIX_W-1:0]          out_read_pixel;
  logic                      out_read_hit;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [1:0]                cfg_index;
  logic [CFG_W-1:0]          cfg_data;

  // Mirror of the pixel store and of the frame registers.
  bit [PIX_W-1:0]   pixel_mirror [STORE_WORDS];
  logic [CFG_W-1:0] frame_w_cfg = FRAME_WIDTH_RST;
  logic [CFG_W-1:0] frame_h_cfg = FRAME_HEIGHT_RST;
  logic [CFG_W-1:0] pitch_cfg   = ROW_PITCH_RST;

  blit_result_t pending_results[$];
  blit_result_t oldest_result;
  int           error_count = 0;
  int           burst_left  = 0;
  int           quiet_cycles = 0;

  rect_fill_shadow_blitter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_rect_x      (in_rect_x),
    .in_rect_y      (in_rect_y),
    .in_rect_w      (in_rect_w),
    .in_rect_h      (in_rect_h),
    .in_fill_color  (in_fill_color),
    .out_valid      (out_valid),
    .out_read_pixel (out_read_pixel),
    .out_read_hit   (out_read_hit),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Fill or darken the clipped rectangle in the mirror store.
  task automatic paint_model(input longint x, input longint y, input longint w,
                             input longint h, input logic [PIX_W-1:0] color,
                             input bit shade);
    longint x0, y0, x1, y1, base, addr;
    logic [PIX_W-1:0] pix;
    x0 = (x < 0) ? 0 : x;
    y0 = (y < 0) ? 0 : y;
    x1 = x + w;
    y1 = y + h;
    if (x1 > longint'(frame_w_cfg)) x1 = longint'(frame_w_cfg);
    if (y1 > longint'(frame_h_cfg)) y1 = longint'(frame_h_cfg);
    for (longint yy = y0; yy < y1; yy++) begin
      base = longint'(pitch_cfg) * yy;
      if (base >= STORE_SIZE) break;
      for (longint xx = x0; xx < x1; xx++) begin
        addr = base + xx;
        if (addr >= STORE_SIZE) break;
        pix = pixel_mirror[addr];
        if (shade) begin
          pixel_mirror[addr] = {8'h00, 8'(pix[23:16] * SHADE_KEEP / CH_MAX),
                                8'(pix[15:8] * SHADE_KEEP / CH_MAX),
                                8'(pix[7:0] * SHADE_KEEP / CH_MAX)};
        end else begin
          pixel_mirror[addr] = color;
        end
      end
    end
  endtask

  // Drive one command, wait until it is taken, then record what it must return.
  task automatic issue_cmd(input op_t op, input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input logic [PIX_W-1:0] color);
    blit_result_t res;
    longint cx, cy, addr, divisor, base;
    logic [7:0] blue;
    start         <= 1'b1;
    in_operation  <= op;
    in_rect_x     <= x;
    in_rect_y     <= y;
    in_rect_w     <= w;
    in_rect_h     <= h;
    in_fill_color <= color;
    do @(posedge clk); while (busy);

    res = '0;
    cx  = x;
    cy  = y;
    case (op)
      OP_FILL:   paint_model(cx, cy, w, h, color, 1'b0);
      OP_SHADOW: paint_model(cx, cy, w, h, '0, 1'b1);
      OP_GRADIENT: begin
        // One blue shade per row over the whole frame.
        divisor = (frame_h_cfg == '0) ? 1 : longint'(frame_h_cfg);
        for (longint yy = 0; yy < longint'(frame_h_cfg); yy++) begin
          base = longint'(pitch_cfg) * yy;
          if (base >= STORE_SIZE) break;
          blue = 8'(GRAD_BLUE_BASE + (GRAD_BLUE_SPAN * yy) / divisor);
          for (longint xx = 0; xx < longint'(frame_w_cfg); xx++) begin
            addr = base + xx;
            if (addr >= STORE_SIZE) break;
            pixel_mirror[addr] = {8'h00, GRAD_RG, blue};
          end
        end
      end
      default: begin
        // A read inside the frame hits, even when it lands past the store.
        if (cx >= 0 && cy >= 0 && cx < longint'(frame_w_cfg) &&
            cy < longint'(frame_h_cfg)) begin
          res.hit = 1'b1;
          addr = longint'(pitch_cfg) * cy + cx;
          if (addr < STORE_SIZE) res.pixel = pixel_mirror[addr];
        end
      end
    endcase
    pending_results.push_back(res);

    // Bursts of back-to-back items separated by random gaps.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 64)
                                               : $urandom_range(0, 5);
    end
  endtask

  // Stop sending and wait until every outstanding item has returned.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the frame registers plus the spare index, with the block idle.
  task automatic program_frame(input int fw, input int fh, input int pitch);
    logic [1:0]       idx_list [4];
    logic [CFG_W-1:0] val_list [4];
    idx_list = '{CFG_IDX_SPARE, CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_ROW_PITCH};
    val_list = '{CFG_W'($urandom), CFG_W'(fw), CFG_W'(fh), CFG_W'(pitch)};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= val_list[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx_list[i])
        CFG_FRAME_WIDTH:  frame_w_cfg = val_list[i];
        CFG_FRAME_HEIGHT: frame_h_cfg = val_list[i];
        CFG_ROW_PITCH:    pitch_cfg   = val_list[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly near the frame, sometimes anywhere in the 16-bit range.
  function automatic logic signed [COORD_W-1:0] pick_coord(input int span);
    int v;
    if ($urandom_range(0, 7) == 0) begin
      v = $urandom_range(0, 65535);
    end else begin
      v = $urandom_range(0, span + 16) - 8;
    end
    return v[COORD_W-1:0];
  endfunction

  // All four operations at the reset frame, with clipping and empty rectangles.
  task automatic test_basic_ops();
    issue_cmd(OP_READ, 16'sd0, 16'sd0, '0, '0, '0);
    issue_cmd(OP_FILL, -16'sd5, -16'sd3, 12'd10, 12'd8, 32'hFFFF_FFFF);
    issue_cmd(OP_READ, 16'sd4, 16'sd4, '0, '0, '0);
    issue_cmd(OP_SHADOW, 16'sd0, 16'sd0, 12'd3, 12'd3, '0);
    issue_cmd(OP_READ, 16'sd1, 16'sd1, '0, '0, '0);
    issue_cmd(OP_FILL, 16'sd250, 16'sd250, 12'hFFF, 12'hFFF, 32'h1234_5678);
    issue_cmd(OP_READ, 16'sd255, 16'sd255, '0, '0, '0);
    issue_cmd(OP_FILL, 16'sd100, 16'sd100, 12'd0, 12'd5, 32'hAAAA_AAAA);
    issue_cmd(OP_FILL, 16'sd100, 16'sd100, 12'd5, 12'd0, 32'h5555_5555);
    issue_cmd(OP_READ, 16'sd100, 16'sd100, '0, '0, '0);
    issue_cmd(OP_READ, -16'sd1, 16'sd0, '0, '0, '0);
    issue_cmd(OP_READ, 16'sd32767, 16'sd32767, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    issue_cmd(OP_GRADIENT, 16'sd0, 16'sd0, '0, '0, '0);
    issue_cmd(OP_READ, 16'sd0, 16'sd0, '0, '0, '0);
    issue_cmd(OP_READ, 16'sd7, 16'sd128, '0, '0, '0);
  endtask

  // Zero pitch, zero height and addresses past the end of the store.
  task automatic test_config_extremes();
    // With zero pitch every row lands on the same words.
    program_frame(8, 4, 0);
    issue_cmd(OP_FILL, 16'sd0, 16'sd0, 12'd8, 12'd4, 32'hC0FF_EE42);
    issue_cmd(OP_SHADOW, 16'sd0, 16'sd0, 12'd8, 12'd4, '0);
    issue_cmd(OP_READ, 16'sd3, 16'sd2, '0, '0, '0);
    issue_cmd(OP_GRADIENT, 16'sd0, 16'sd0, '0, '0, '0);
    issue_cmd(OP_READ, 16'sd2, 16'sd1, '0, '0, '0);
    // A frame with no rows draws nothing.
    program_frame(16, 0, 16);
    issue_cmd(OP_GRADIENT, 16'sd0, 16'sd0, '0, '0, '0);
    issue_cmd(OP_READ, 16'sd0, 16'sd0, '0, '0, '0);
    // Widest frame; rows from nine on fall past the store.
    program_frame(8191, 12, 8191);
    issue_cmd(OP_READ, 16'sd0, 16'sd9, '0, '0, '0);
    issue_cmd(OP_FILL, 16'sd0, 16'sd8, 12'd20, 12'd2, 32'h5A5A_A5A5);
    issue_cmd(OP_READ, 16'sd7, 16'sd8, '0, '0, '0);
    issue_cmd(OP_READ, 16'sd8, 16'sd8, '0, '0, '0);
  endtask

  // Random commands under one frame setting.
  task automatic run_phase(input int fw, input int fh, input int pitch, input int count);
    op_t                       op;
    logic signed [COORD_W-1:0] x, y;
    logic [SIZE_W-1:0]         w, h;
    int                        sel, grad_pct;
    longint                    area;
    program_frame(fw, fh, pitch);
    // Gradients repaint the whole frame, so keep them rare on big frames.
    area = longint'(fw) * fh;
    grad_pct = (area <= 4096) ? 3 : (area <= 100000) ? 1 : 0;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < grad_pct) op = OP_GRADIENT;
      else if (sel < 45) op = OP_READ;
      else if (sel < 75) op = OP_FILL;
      else op = OP_SHADOW;
      x = pick_coord(fw);
      y = pick_coord(fh);
      // Mostly small rectangles; long thin ones reach every size bit.
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        w = SIZE_W'($urandom_range(0, 4095));
        h = SIZE_W'($urandom_range(0, 3));
      end else if (sel == 1) begin
        w = SIZE_W'($urandom_range(0, 3));
        h = SIZE_W'($urandom_range(0, 4095));
      end else begin
        w = SIZE_W'($urandom_range(0, 24));
        h = SIZE_W'($urandom_range(0, 24));
      end
      issue_cmd(op, x, y, w, h, $urandom);
    end
  endtask

  // Random traffic over a range of frame shapes, extremes included.
  task automatic test_random_traffic();
    run_phase(256, 256, 256, 120);
    run_phase(64, 48, 100, 100);
    run_phase(100, 40, 50, 80);
    run_phase(8191, 12, 8191, 60);
    run_phase(4096, 4096, 16, 80);
    run_phase(0, 30, 40, 20);
    run_phase(40, 0, 0, 20);
    run_phase(32, 24, 0, 50);
    run_phase(20, 20, 20, 50);
  endtask

  // Compare each returned item with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: read_pixel %h read_hit %b", out_read_pixel,
               out_read_hit);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_read_pixel !== oldest_result.pixel) begin
          $error("read_pixel: expected %h, actual %h", oldest_result.pixel,
                 out_read_pixel);
          error_count++;
        end
        if (out_read_hit !== oldest_result.hit) begin
          $error("read_hit: expected %b, actual %b", oldest_result.hit, out_read_hit);
          error_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** rect_fill_shadow_blitter: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset, run the tests in turn, drain and report.
  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_operation  <= OP_FILL;
    in_rect_x     <= '0;
    in_rect_y     <= '0;
    in_rect_w     <= '0;
    in_rect_h     <= '0;
    in_fill_color <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_FRAME_WIDTH;
    cfg_data      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_config_extremes();
    test_random_traffic();
    wait_idle();

    if (error_count == 0) begin
      $display("** rect_fill_shadow_blitter: PASSED **");
    end else begin
      $display("** rect_fill_shadow_blitter: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rfsb_pkg.sv
hw/rtl/rfsb_store.sv
hw/rtl/rect_fill_shadow_blitter.sv
tb/tb.sv
